@@ hw/rtl/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the spiral matrix scan core: configuration
// register indexes, item operation codes, field widths and the shape bundle.
// ----------------------------------------------------------------------------
package sms_pkg;

    // Configuration register file
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 5'd1;
    localparam logic [CFG_W-1:0] COL_COUNT_RST = 5'd1;

    // Parameter defaults
    localparam int MAX_ROWS_DEF   = 16;
    localparam int MAX_COLS_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Element counters hold up to rows * cols
    localparam int CNT_W = 2 * CFG_W;

    // Signed spiral position arithmetic (ring, cursor, bounds)
    localparam int POS_W = CFG_W + 2;

    // Output index fields
    localparam int IDX_OUT_W = 4;

    // Position search gives up after this many side steps
    localparam int NORM_STEPS = 12;
    localparam int NORM_K_W   = 4;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Item operations
    typedef logic [0:0] op_t;
    localparam op_t OP_LOAD = 1'b0;
    localparam op_t OP_EMIT = 1'b1;

    // Ring sides in walk order
    typedef logic [1:0] side_t;
    localparam side_t SIDE_TOP    = 2'd0;
    localparam side_t SIDE_RIGHT  = 2'd1;
    localparam side_t SIDE_BOTTOM = 2'd2;
    localparam side_t SIDE_LEFT   = 2'd3;

    // Effective matrix shape
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [CNT_W-1:0] total;
    } shape_t;

endpackage

@@ hw/rtl/sms_front.sv @@
// ----------------------------------------------------------------------------
// sms_front
// Input side: accepts items from the s_ channel, drops everything while the
// matrix is empty, and encodes the rest as load or emit operations.
// ----------------------------------------------------------------------------
module sms_front #(
    parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [DATA_WIDTH-1:0] s_value,
    input  sms_pkg::shape_t       shape,
    input  logic                  q_full,
    output logic                  q_push,
    output sms_pkg::op_t          q_push_op,
    output logic [DATA_WIDTH-1:0] q_push_value
);

    logic accept;
    logic empty_matrix;

    // Take an item whenever the queue has room
    assign s_ready      = !q_full;
    assign accept       = s_valid && s_ready;
    assign empty_matrix = (shape.total == '0);

    // Drop items for an empty matrix, forward the rest
    assign q_push       = accept && !empty_matrix;
    assign q_push_op    = s_kind ? sms_pkg::OP_EMIT : sms_pkg::OP_LOAD;
    assign q_push_value = s_value;

    // Every accepted item for a non-empty matrix reaches the queue
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !empty_matrix) |-> q_push)
        else $error("accepted item not queued");

endmodule

@@ hw/rtl/sms_queue.sv @@
// ----------------------------------------------------------------------------
// sms_queue
// Two-entry queue between front and back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module sms_queue #(
    parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sms_pkg::op_t          push_op,
    input  logic [DATA_WIDTH-1:0] push_value,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output sms_pkg::op_t          pop_op,
    output logic [DATA_WIDTH-1:0] pop_value
);

    sms_pkg::op_t                  op_reg    [sms_pkg::Q_DEPTH];
    logic [DATA_WIDTH-1:0]         value_reg [sms_pkg::Q_DEPTH];
    logic [sms_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sms_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sms_pkg::Q_CNT_W-1:0]   count_reg,  count_next;
    logic                          do_push, do_pop;

    assign full      = (count_reg == sms_pkg::Q_CNT_W'(sms_pkg::Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = op_reg[rd_ptr_reg];
    assign pop_value = value_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            op_reg[wr_ptr_reg]    <= push_op;
            value_reg[wr_ptr_reg] <= push_value;
        end
    end

    // Fill level never passes the depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sms_pkg::Q_CNT_W'(sms_pkg::Q_DEPTH))
        else $error("queue overflow");

endmodule

@@ hw/rtl/sms_back.sv @@
// ----------------------------------------------------------------------------
// sms_back
// Execution side: owns the matrix memory, load and scan counters and the
// spiral position. Loads write one word until the matrix is full; emits, once
// it is full and the scan is not done, walk the position to a valid spot one
// side step per cycle, read the word and hand it to the output register.
// ----------------------------------------------------------------------------
module sms_back #(
    parameter int MAX_ROWS   = sms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = sms_pkg::MAX_COLS_DEF,
    parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sms_pkg::shape_t                   shape,
    input  logic                              q_valid,
    input  sms_pkg::op_t                      q_op,
    input  logic [DATA_WIDTH-1:0]             q_value,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [DATA_WIDTH-1:0]             m_value_res,
    output logic [sms_pkg::IDX_OUT_W-1:0]     m_row,
    output logic [sms_pkg::IDX_OUT_W-1:0]     m_col,
    output logic                              m_last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = sms_pkg::POS_W;
    localparam int CNT_W  = sms_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NORM = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    typedef struct packed {
        logic                    ok;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
    } bounds_t;

    // Walk range of one side of one ring
    function automatic bounds_t side_bounds(
        input logic signed [POS_W-1:0] g,
        input sms_pkg::side_t          s,
        input logic [sms_pkg::CFG_W-1:0] nr,
        input logic [sms_pkg::CFG_W-1:0] nc
    );
        bounds_t                 b;
        logic signed [POS_W-1:0] top, bot, lft, rgt;
        top = g;
        lft = g;
        bot = $signed(POS_W'(nr)) - POS_W'(1) - g;
        rgt = $signed(POS_W'(nc)) - POS_W'(1) - g;
        b.ok = 1'b0;
        b.lo = lft;
        b.hi = rgt;
        unique case (s)
            sms_pkg::SIDE_TOP: begin
                b.ok = 1'b1;
                b.lo = lft;
                b.hi = rgt;
            end
            sms_pkg::SIDE_RIGHT: begin
                b.ok = 1'b1;
                b.lo = top + POS_W'(1);
                b.hi = bot;
            end
            sms_pkg::SIDE_BOTTOM: begin
                b.ok = (bot > top);
                b.lo = lft;
                b.hi = rgt - POS_W'(1);
            end
            default: begin
                b.ok = (rgt > lft);
                b.lo = top + POS_W'(1);
                b.hi = bot - POS_W'(1);
            end
        endcase
        if (top > bot || lft > rgt) begin
            b.ok = 1'b0;
        end
        return b;
    endfunction

    logic [1:0]                    state_reg,   state_next;
    logic [CNT_W-1:0]              loaded_reg,  loaded_next;
    logic [CNT_W-1:0]              emitted_reg, emitted_next;
    logic signed [POS_W-1:0]       ring_reg,    ring_next;
    sms_pkg::side_t                side_reg,    side_next;
    logic signed [POS_W-1:0]       cursor_reg,  cursor_next;
    logic [sms_pkg::NORM_K_W-1:0]  norm_k_reg,  norm_k_next;
    logic                          m_valid_reg, m_valid_next;

    logic [DATA_WIDTH-1:0]         mem [DEPTH];
    logic [DATA_WIDTH-1:0]         rd_data_reg;
    logic [sms_pkg::IDX_OUT_W-1:0] row_reg, col_reg;
    logic                          last_reg;
    logic [DATA_WIDTH-1:0]         m_value_res_reg;
    logic [sms_pkg::IDX_OUT_W-1:0] m_row_reg, m_col_reg;
    logic                          m_last_reg;

    logic                          mem_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [CNT_W-1:0]              load_base;
    logic                          scan_done;
    bounds_t                       cur_b, adv_b;
    logic                          cur_ok;
    sms_pkg::side_t                adv_side;
    logic signed [POS_W-1:0]       adv_ring, adv_lo, adv_hi, adv_cursor;
    logic signed [POS_W-1:0]       pos_r, pos_c;
    logic [CNT_W-1:0]              rd_idx;
    logic                          out_free, out_load;

    assign scan_done = (emitted_reg >= shape.total);
    assign load_base = scan_done ? '0 : loaded_reg;
    assign wr_addr   = ADDR_W'(load_base);
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == S_OUT) && out_free;

    // Check current position and prepare one side step
    always_comb begin
        cur_b    = side_bounds(ring_reg, side_reg, shape.rows, shape.cols);
        cur_ok   = cur_b.ok && (cur_b.lo <= cur_b.hi) &&
                   (cursor_reg >= cur_b.lo) && (cursor_reg <= cur_b.hi);
        adv_side = side_reg + 2'd1;
        adv_ring = (adv_side == sms_pkg::SIDE_TOP) ? ring_reg + POS_W'(1) : ring_reg;
        adv_b    = side_bounds(adv_ring, adv_side, shape.rows, shape.cols);
        adv_lo   = adv_b.ok ? adv_b.lo : '0;
        adv_hi   = adv_b.ok ? adv_b.hi : '0;
        adv_cursor = (adv_side < sms_pkg::SIDE_BOTTOM) ? adv_lo : adv_hi;
    end

    // Map position to matrix row and column, clamp below zero
    always_comb begin
        pos_r = ring_reg;
        pos_c = cursor_reg;
        unique case (side_reg)
            sms_pkg::SIDE_TOP: begin
                pos_r = ring_reg;
                pos_c = cursor_reg;
            end
            sms_pkg::SIDE_RIGHT: begin
                pos_r = cursor_reg;
                pos_c = $signed(POS_W'(shape.cols)) - POS_W'(1) - ring_reg;
            end
            sms_pkg::SIDE_BOTTOM: begin
                pos_r = $signed(POS_W'(shape.rows)) - POS_W'(1) - ring_reg;
                pos_c = cursor_reg;
            end
            default: begin
                pos_r = cursor_reg;
                pos_c = ring_reg;
            end
        endcase
        if (pos_r < 0) begin
            pos_r = '0;
        end
        if (pos_c < 0) begin
            pos_c = '0;
        end
        rd_idx = CNT_W'(pos_r[sms_pkg::CFG_W-1:0]) * CNT_W'(shape.cols) +
                 CNT_W'(pos_c[sms_pkg::CFG_W-1:0]);
    end

    // Sequencer: take one queued operation and carry it out
    always_comb begin
        state_next   = state_reg;
        loaded_next  = loaded_reg;
        emitted_next = emitted_reg;
        ring_next    = ring_reg;
        side_next    = side_reg;
        cursor_next  = cursor_reg;
        norm_k_next  = norm_k_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_op == sms_pkg::OP_LOAD) begin
                        // a load after the scan ends starts over
                        if (scan_done) begin
                            emitted_next = '0;
                            ring_next    = '0;
                            side_next    = sms_pkg::SIDE_TOP;
                            cursor_next  = '0;
                        end
                        loaded_next = load_base;
                        if (load_base < shape.total) begin
                            mem_we      = 1'b1;
                            loaded_next = load_base + 1'b1;
                        end
                    end else if (loaded_reg >= shape.total && !scan_done) begin
                        norm_k_next = '0;
                        state_next  = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (norm_k_reg == sms_pkg::NORM_K_W'(sms_pkg::NORM_STEPS)) begin
                    // no valid spot found: restart at the first element
                    ring_next   = '0;
                    side_next   = sms_pkg::SIDE_TOP;
                    cursor_next = '0;
                    state_next  = S_READ;
                end else if (cur_ok) begin
                    state_next = S_READ;
                end else begin
                    ring_next   = adv_ring;
                    side_next   = adv_side;
                    cursor_next = adv_cursor;
                    norm_k_next = norm_k_reg + 1'b1;
                end
            end
            S_READ: begin
                cursor_next  = (side_reg < sms_pkg::SIDE_BOTTOM) ?
                               cursor_reg + POS_W'(1) : cursor_reg - POS_W'(1);
                emitted_next = emitted_reg + 1'b1;
                state_next   = S_OUT;
            end
            default: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            loaded_reg  <= '0;
            emitted_reg <= '0;
            ring_reg    <= '0;
            side_reg    <= sms_pkg::SIDE_TOP;
            cursor_reg  <= '0;
            norm_k_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            emitted_reg <= emitted_next;
            ring_reg    <= ring_next;
            side_reg    <= side_next;
            cursor_reg  <= cursor_next;
            norm_k_reg  <= norm_k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Matrix memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_value;
        end
        if (state_reg == S_READ) begin
            rd_data_reg <= mem[ADDR_W'(rd_idx)];
        end
    end

    // Capture element coordinates and end flag alongside the read
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            row_reg  <= pos_r[sms_pkg::IDX_OUT_W-1:0];
            col_reg  <= pos_c[sms_pkg::IDX_OUT_W-1:0];
            last_reg <= (emitted_reg + 1'b1 == shape.total);
        end
    end

    // Output register: hold while stalled, load when free
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_res_reg <= rd_data_reg;
            m_row_reg       <= row_reg;
            m_col_reg       <= col_reg;
            m_last_reg      <= last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value_res = m_value_res_reg;
    assign m_row       = m_row_reg;
    assign m_col       = m_col_reg;
    assign m_last      = m_last_reg;

    // Position search is bounded
    a_norm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NORM) |-> (norm_k_reg <= sms_pkg::NORM_K_W'(sms_pkg::NORM_STEPS)))
        else $error("position search ran past its step limit");

    // Memory writes and queue pops happen only between operations
    a_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || q_pop) |-> (state_reg == S_IDLE))
        else $error("write or pop outside idle");

    // A read is always followed by the hand-off state
    a_read_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (state_reg == S_OUT))
        else $error("read not followed by output stage");

    // A result is loaded only after the scan counter moved
    a_out_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (emitted_reg == $past(emitted_reg) + 1'b1))
        else $error("emit without count advance");

endmodule

@@ hw/rtl/spiral_matrix_scan_core.sv @@
// ----------------------------------------------------------------------------
// spiral_matrix_scan_core
// Loads a matrix row-major and returns its elements in clockwise spiral order.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_kind, s_value
//   m_       out        m_valid/m_ready    m_value_res, m_row, m_col, m_last
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// A load, or an emit that gives nothing, is handled in the idle state alone;
// items for an empty matrix are dropped at the input and never reach it.
// An emit passes the dequeue, position check, memory read and output states
// in turn; the check takes one side step at a time when the position turns
// a corner, up to NORM_STEPS steps, and the output state waits while the
// output register is stalled. The sequencer takes one operation at a time.
// Reset is synchronous, active low, and clears counters and position; the
// memory is not cleared. A stalled output holds the result while up to two
// more items queue at the input.
// ----------------------------------------------------------------------------
module spiral_matrix_scan_core #(
    parameter int MAX_ROWS   = sms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = sms_pkg::MAX_COLS_DEF,
    parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sms_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [DATA_WIDTH-1:0]             s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [DATA_WIDTH-1:0]             m_value_res,
    output logic [sms_pkg::IDX_OUT_W-1:0]     m_row,
    output logic [sms_pkg::IDX_OUT_W-1:0]     m_col,
    output logic                              m_last
);

    logic [sms_pkg::CFG_W-1:0] row_count_reg, row_count_next;
    logic [sms_pkg::CFG_W-1:0] col_count_reg, col_count_next;
    sms_pkg::shape_t           shape;
    logic                      q_full, q_push, q_pop, q_valid;
    sms_pkg::op_t              q_push_op, q_op;
    logic [DATA_WIDTH-1:0]     q_push_value, q_value;

    // Configuration writes
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                sms_pkg::REG_ROW_COUNT: row_count_next = cfg_data;
                sms_pkg::REG_COL_COUNT: col_count_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= sms_pkg::ROW_COUNT_RST;
            col_count_reg <= sms_pkg::COL_COUNT_RST;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Clamp counts to the stored size and form the element total
    always_comb begin
        shape.rows  = (row_count_reg > MAX_ROWS) ?
                      sms_pkg::CFG_W'(MAX_ROWS) : row_count_reg;
        shape.cols  = (col_count_reg > MAX_COLS) ?
                      sms_pkg::CFG_W'(MAX_COLS) : col_count_reg;
        shape.total = sms_pkg::CNT_W'(shape.rows) * sms_pkg::CNT_W'(shape.cols);
    end

    sms_front #(
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_value      (s_value),
        .shape        (shape),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_op    (q_push_op),
        .q_push_value (q_push_value)
    );

    sms_queue #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_push_op),
        .push_value (q_push_value),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_op     (q_op),
        .pop_value  (q_value)
    );

    sms_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shape       (shape),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .q_value     (q_value),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_res (m_value_res),
        .m_row       (m_row),
        .m_col       (m_col),
        .m_last      (m_last)
    );

endmodule
